[sv/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants for the 2d spring force pipeline
// ----------------------------------------------------------------------------
package sfd_pkg;

    // register file geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STIFF_W    = 32;
    localparam int REST_W     = 31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 2'd1;

    // reset values: stiffness 1.0 in q16.16, rest length zero
    localparam logic [STIFF_W-1:0] STIFF_RESET = 32'h0001_0000;
    localparam logic [REST_W-1:0]  REST_RESET  = '0;

endpackage

[sv/sfd_isqrt.sv]
// ----------------------------------------------------------------------------
// sfd_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sfd_isqrt #(
    parameter int RW = 33
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    logic [2*RW-1:0] rad_reg  [0:RW-1];
    logic [RW:0]     rem_reg  [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [2*RW-1:0] prad;
        logic [RW:0]     prem;
        logic [RW-1:0]   proot;
        logic [RW+2:0]   shv;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;
        logic            ge;

        if (g == 0) begin : g_first
            assign prad  = rad;
            assign prem  = '0;
            assign proot = '0;
        end
        else begin : g_next
            assign prad  = rad_reg[g-1];
            assign prem  = rem_reg[g-1];
            assign proot = root_reg[g-1];
        end

        // bring down two radicand bits, try (root << 2) | 1
        assign shv   = {prem, prad[2*RW-1 -: 2]};
        assign trial = {1'b0, proot, 2'b01};
        assign ge    = shv >= trial;
        assign diff  = shv - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= prad << 2;
                rem_reg[g]  <= ge ? diff[RW:0] : shv[RW:0];
                root_reg[g] <= {proot[RW-2:0], ge};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

[sv/sfd_udiv.sv]
// ----------------------------------------------------------------------------
// sfd_udiv
// pipelined restoring divider, round(mag * 2^fb / den) with mag <= den
// ----------------------------------------------------------------------------
module sfd_udiv #(
    parameter int DW = 33,
    parameter int FB = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] mag,
    input  logic [DW-1:0] den,
    output logic [FB:0]   quo
);

    logic [DW-1:0] r_reg   [0:FB];
    logic [FB:0]   q_reg   [0:FB];
    logic [DW-1:0] den_reg [0:FB];
    logic [FB:0]   quo_reg;

    for (genvar g = 0; g <= FB; g++) begin : g_stage
        logic [DW:0]   shv;
        logic [DW:0]   diff;
        logic [DW-1:0] pden;
        logic [FB:0]   pq;
        logic          ge;

        if (g == 0) begin : g_first
            // integer quotient bit: mag >= den
            assign shv  = {1'b0, mag};
            assign pden = den;
            assign pq   = '0;
        end
        else begin : g_next
            assign shv  = {r_reg[g-1], 1'b0};
            assign pden = den_reg[g-1];
            assign pq   = q_reg[g-1];
        end

        assign ge   = shv >= {1'b0, pden};
        assign diff = shv - {1'b0, pden};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[g]   <= ge ? diff[DW-1:0] : shv[DW-1:0];
                q_reg[g]   <= {pq[FB-1:0], ge};
                den_reg[g] <= pden;
            end
        end
    end

    // round half away from zero: bump when 2r >= den
    logic round_up;
    assign round_up = {r_reg[FB], 1'b0} >= {1'b0, den_reg[FB]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= q_reg[FB] + {{FB{1'b0}}, round_up};
        end
    end

    assign quo = quo_reg;

endmodule

[sv/spring_force_2d_top.sv]
// ----------------------------------------------------------------------------
// spring_force_2d_top
// 2d hooke spring force kernel, fully pipelined; while the output is taken, one body pair per cycle
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      positions a, b and movable flags
//  m_axis    out  m_axis_tvalid/tready      forces on a and b plus flags
//  cfg       in   cfg_valid/cfg_ready       register index and write data
//
//  one request enters every cycle while the pipeline advances; the pipeline
//  depth is set by the one-bit-per-stage square root and the
//  one-bit-per-stage unit vector dividers
//  the whole pipeline advances on one enable; a result not taken freezes it
//  and s_axis_tready drops until m_axis_tready frees the output register
//  reset clears the valid bits and loads stiffness 1.0 and rest length 0
//  configuration is taken any cycle and used directly by the stretch and
//  multiply stages, so write it only while the pipeline is empty
// ----------------------------------------------------------------------------
module spring_force_2d_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic clk,
    input  logic rst_n,

    // pos_a_x, pos_a_y, pos_b_x, pos_b_y, a_movable, b_movable, zero pad
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((4*COORD_WIDTH+2+7)/8)*8-1:0]   s_axis_tdata,

    // force_a_x, force_a_y, force_b_x, force_b_y, apply_to_a, apply_to_b,
    // coincident, saturated, zero pad
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((4*COORD_WIDTH+4+7)/8)*8-1:0]   m_axis_tdata,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]         cfg_data
);

    import sfd_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;                // signed offset / magnitude
    localparam int RW     = CW + 1;                // root width
    localparam int SQW    = 2 * RW;                // radicand width
    localparam int LH     = (DW + 1) / 2;          // low half for squaring
    localparam int HW     = DW - LH;
    localparam int SM     = (RW > REST_W) ? RW : REST_W;  // stretch magnitude
    localparam int HS     = (SM + 1) / 2;
    localparam int SHW    = SM - HS;
    localparam int MW     = SM + STIFF_W;          // stretch times stiffness
    localparam int UW     = FRAC_BITS + 1;         // unit component
    localparam int MH     = (MW + 1) / 2;
    localparam int MHW    = MW - MH;
    localparam int PW     = MW + UW + 1;
    localparam int GW     = PW - (2 * FRAC_BITS + 1);
    localparam int LAT    = RW + FRAC_BITS + 12;
    localparam int IN_TW  = ((4 * CW + 2 + 7) / 8) * 8;
    localparam int OUT_TW = ((4 * CW + 4 + 7) / 8) * 8;

    localparam logic [GW-1:0] LIM_P = {{(GW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [GW-1:0] LIM_N = {{(GW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [DW-1:0] ax;
        logic [DW-1:0] ay;
        logic          nx;
        logic          ny;
        logic          coin;
        logic          am;
        logic          bm;
    } geo_t;

    typedef struct packed {
        logic          sneg;
        logic          nx;
        logic          ny;
        logic          coin;
        logic          am;
        logic          bm;
    } flag_t;

    typedef struct packed {
        logic [SM-1:0] smag;
        flag_t         fl;
    } dv_t;

    typedef struct packed {
        logic [CW-1:0] val;
        logic          clip;
    } sat_t;

    // ---------------------------------------------------------------- config
    logic [STIFF_W-1:0] stiff_reg;
    logic [REST_W-1:0]  rest_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
            rest_reg  <= REST_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STIFFNESS: stiff_reg <= cfg_data[STIFF_W-1:0];
                REG_REST_LEN:  rest_reg  <= cfg_data[REST_W-1:0];
                default:       ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------ flow control
    // single enable for every stage; valid bits ride along in vld_reg
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv           = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------------------------------------------- stage 0: offset b-a
    logic [CW-1:0] in_ax, in_ay, in_bx, in_by;
    logic [DW-1:0] dx_reg, dy_reg;
    logic          am0_reg, bm0_reg;

    assign in_ax = s_axis_tdata[CW-1:0];
    assign in_ay = s_axis_tdata[2*CW-1:CW];
    assign in_bx = s_axis_tdata[3*CW-1:2*CW];
    assign in_by = s_axis_tdata[4*CW-1:3*CW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= {in_bx[CW-1], in_bx} - {in_ax[CW-1], in_ax};
            dy_reg  <= {in_by[CW-1], in_by} - {in_ay[CW-1], in_ay};
            am0_reg <= s_axis_tdata[4*CW];
            bm0_reg <= s_axis_tdata[4*CW+1];
        end
    end

    // -------------------------------------------- stage 1: magnitudes, signs
    geo_t g1_reg, g2_reg, g3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg.ax   <= dx_reg[DW-1] ? (~dx_reg + 1'b1) : dx_reg;
            g1_reg.ay   <= dy_reg[DW-1] ? (~dy_reg + 1'b1) : dy_reg;
            g1_reg.nx   <= dx_reg[DW-1];
            g1_reg.ny   <= dy_reg[DW-1];
            g1_reg.coin <= (dx_reg == '0) && (dy_reg == '0);
            g1_reg.am   <= am0_reg;
            g1_reg.bm   <= bm0_reg;
        end
    end

    // --------------------------- stage 2: squares as split partial products
    logic [2*HW-1:0]  xhh_reg, yhh_reg;
    logic [HW+LH-1:0] xhl_reg, yhl_reg;
    logic [2*LH-1:0]  xll_reg, yll_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xhh_reg <= g1_reg.ax[DW-1:LH] * g1_reg.ax[DW-1:LH];
            xhl_reg <= g1_reg.ax[DW-1:LH] * g1_reg.ax[LH-1:0];
            xll_reg <= g1_reg.ax[LH-1:0]  * g1_reg.ax[LH-1:0];
            yhh_reg <= g1_reg.ay[DW-1:LH] * g1_reg.ay[DW-1:LH];
            yhl_reg <= g1_reg.ay[DW-1:LH] * g1_reg.ay[LH-1:0];
            yll_reg <= g1_reg.ay[LH-1:0]  * g1_reg.ay[LH-1:0];
            g2_reg  <= g1_reg;
        end
    end

    // -------------------------------------------- stage 3: dx^2 + dy^2 sum
    logic [SQW-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= (SQW'(xhh_reg) << (2 * LH)) + (SQW'(xhl_reg) << (LH + 1))
                    + SQW'(xll_reg)
                    + (SQW'(yhh_reg) << (2 * LH)) + (SQW'(yhl_reg) << (LH + 1))
                    + SQW'(yll_reg);
            g3_reg <= g2_reg;
        end
    end

    // ------------------------------------------------- square root, RW stages
    logic [RW-1:0] root;
    geo_t          gsq_reg [0:RW-1];

    sfd_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sq_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gsq_reg[0] <= g3_reg;
            for (int i = 1; i < RW; i++)
            begin
                gsq_reg[i] <= gsq_reg[i-1];
            end
        end
    end

    // --------------------------------------------- stretch = dist - rest
    logic [SM:0]   s_w;
    logic [SM:0]   s_neg_w;
    logic [RW-1:0] dist_reg;
    geo_t          gst_reg;
    dv_t           dst_reg;

    assign s_w     = {1'b0, SM'(root)} - {1'b0, SM'(rest_reg)};
    assign s_neg_w = ~s_w + 1'b1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg        <= root;
            gst_reg         <= gsq_reg[RW-1];
            dst_reg.smag    <= s_w[SM] ? s_neg_w[SM-1:0] : s_w[SM-1:0];
            dst_reg.fl.sneg <= s_w[SM];
            dst_reg.fl.nx   <= gsq_reg[RW-1].nx;
            dst_reg.fl.ny   <= gsq_reg[RW-1].ny;
            dst_reg.fl.coin <= gsq_reg[RW-1].coin;
            dst_reg.fl.am   <= gsq_reg[RW-1].am;
            dst_reg.fl.bm   <= gsq_reg[RW-1].bm;
        end
    end

    // ----------------------------- unit vector components, FRAC_BITS+2 stages
    logic [UW-1:0] ux, uy;
    dv_t           dv_reg [0:FRAC_BITS+1];

    sfd_udiv #(
        .DW (DW),
        .FB (FRAC_BITS)
    ) u_div_x (
        .clk (clk),
        .en  (adv),
        .mag (gst_reg.ax),
        .den (dist_reg),
        .quo (ux)
    );

    sfd_udiv #(
        .DW (DW),
        .FB (FRAC_BITS)
    ) u_div_y (
        .clk (clk),
        .en  (adv),
        .mag (gst_reg.ay),
        .den (dist_reg),
        .quo (uy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dst_reg;
            for (int i = 1; i <= FRAC_BITS + 1; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    // --------------------------------- m1: stretch * stiffness partial products
    logic [HS+STIFF_W-1:0]  pk0_reg;
    logic [SHW+STIFF_W-1:0] pk1_reg;
    logic [UW-1:0]          ux1_reg, uy1_reg, ux2_reg, uy2_reg;
    flag_t                  fl1_reg, fl2_reg, fl3_reg, fl4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pk0_reg <= dv_reg[FRAC_BITS+1].smag[HS-1:0]  * stiff_reg;
            pk1_reg <= dv_reg[FRAC_BITS+1].smag[SM-1:HS] * stiff_reg;
            ux1_reg <= ux;
            uy1_reg <= uy;
            fl1_reg <= dv_reg[FRAC_BITS+1].fl;
        end
    end

    // --------------------------------------------------------- m2: combine
    logic [MW-1:0] m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg   <= MW'(pk0_reg) + (MW'(pk1_reg) << HS);
            ux2_reg <= ux1_reg;
            uy2_reg <= uy1_reg;
            fl2_reg <= fl1_reg;
        end
    end

    // ---------------------------------------- m3: times unit, split products
    logic [MH+UW-1:0]  px0_reg, py0_reg;
    logic [MHW+UW-1:0] px1_reg, py1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg <= m_reg[MH-1:0]  * ux2_reg;
            px1_reg <= m_reg[MW-1:MH] * ux2_reg;
            py0_reg <= m_reg[MH-1:0]  * uy2_reg;
            py1_reg <= m_reg[MW-1:MH] * uy2_reg;
            fl3_reg <= fl2_reg;
        end
    end

    // ------------------------------------- m4: sum, round, drop 2F+1 bits
    logic [PW-1:0] px_w, py_w;
    logic [GW-1:0] gx_reg, gy_reg;

    assign px_w = PW'(px0_reg) + (PW'(px1_reg) << MH) + (PW'(1) << (2 * FRAC_BITS));
    assign py_w = PW'(py0_reg) + (PW'(py1_reg) << MH) + (PW'(1) << (2 * FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg  <= px_w[PW-1:2*FRAC_BITS+1];
            gy_reg  <= py_w[PW-1:2*FRAC_BITS+1];
            fl4_reg <= fl3_reg;
        end
    end

    // ------------------------------------------- saturate and sign, output reg
    function automatic sat_t sat_fn(input logic [GW-1:0] mag, input logic neg);
        logic [GW-1:0] lim;
        logic [CW-1:0] v;
        sat_t          r;
        lim    = neg ? LIM_N : LIM_P;
        r.clip = mag > lim;
        v      = r.clip ? lim[CW-1:0] : mag[CW-1:0];
        r.val  = neg ? (~v + 1'b1) : v;
        return r;
    endfunction

    logic neg_ax, neg_ay;
    sat_t sax, say, sbx, sby;

    assign neg_ax = fl4_reg.sneg ^ fl4_reg.nx;
    assign neg_ay = fl4_reg.sneg ^ fl4_reg.ny;
    assign sax    = sat_fn(gx_reg, neg_ax);
    assign say    = sat_fn(gy_reg, neg_ay);
    assign sbx    = sat_fn(gx_reg, !neg_ax);
    assign sby    = sat_fn(gy_reg, !neg_ay);

    logic [CW-1:0] fax_reg, fay_reg, fbx_reg, fby_reg;
    logic          apa_reg, apb_reg, coin_reg, sat_reg;
    logic          live_a, live_b;

    assign live_a = fl4_reg.am && !fl4_reg.coin;
    assign live_b = fl4_reg.bm && !fl4_reg.coin;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fax_reg  <= live_a ? sax.val : '0;
            fay_reg  <= live_a ? say.val : '0;
            fbx_reg  <= live_b ? sbx.val : '0;
            fby_reg  <= live_b ? sby.val : '0;
            apa_reg  <= fl4_reg.am;
            apb_reg  <= fl4_reg.bm;
            coin_reg <= fl4_reg.coin;
            sat_reg  <= (live_a && (sax.clip || say.clip))
                     || (live_b && (sbx.clip || sby.clip));
        end
    end

    assign m_axis_tdata = OUT_TW'({sat_reg, coin_reg, apb_reg, apa_reg,
                                   fby_reg, fbx_reg, fay_reg, fax_reg});

    // ----------------------------------------------------------- assertions
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_coin_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && coin_reg) |-> (fax_reg == '0 && fay_reg == '0
            && fbx_reg == '0 && fby_reg == '0 && !sat_reg))
        else $error("coincident result carries force");

    a_static_a : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !apa_reg) |-> (fax_reg == '0 && fay_reg == '0))
        else $error("force on static body a");

    a_static_b : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !apb_reg) |-> (fbx_reg == '0 && fby_reg == '0))
        else $error("force on static body b");

    a_sat_cause : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && sat_reg) |-> ((apa_reg || apb_reg) && !coin_reg))
        else $error("saturation flag without a movable body");

endmodule

[verif/spring_force_2d_top_tb.sv]
// ----------------------------------------------------------------------------
// spring_force_2d_top_tb
// self-checking bench for the 2d spring force pipeline
// ----------------------------------------------------------------------------
// body pairs go in on s_axis and forces come out on m_axis, in order. a
// scoreboard works out the expected forces from its own copy of the
// stiffness and rest length registers and checks every field of every
// result. the run steps through several register settings and idling mixes,
// with a long output hold-off that backs the pipeline up into its input
// ----------------------------------------------------------------------------
class force_scoreboard;
    logic [31:0]  stiffness = sfd_pkg::STIFF_RESET;
    logic [30:0]  rest_len  = sfd_pkg::REST_RESET;
    logic [135:0] pending_forces[$];
    int           errors = 0;

    // one force component: returns {clip, value}
    function logic [32:0] force_comp(logic [127:0] smag, logic sneg, logic dneg,
                                     logic [127:0] mag, logic [127:0] span,
                                     logic flip);
        logic [127:0] u, rem, fm, lim;
        logic         neg, clip;
        logic [31:0]  v;
        u   = (mag << 16) / span;
        rem = (mag << 16) % span;
        if (rem >= span - rem)
            u++;
        fm   = (smag * stiffness * u + (128'd1 << 32)) >> 33;
        neg  = (sneg != dneg) ^ flip;
        lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        clip = fm > lim;
        v    = clip ? lim[31:0] : fm[31:0];
        return {clip, neg ? -v : v};
    endfunction

    function void note_pair(logic [135:0] d);
        logic signed [31:0] pax, pay, pbx, pby;
        logic signed [32:0] dx, dy;
        logic [127:0]       ax, ay, sq, c, span, smag;
        logic               am, bm, coin, sneg, clip;
        logic [32:0]        r;
        logic [31:0]        fa[2], fb[2];
        pax = d[31:0];  pay = d[63:32];  pbx = d[95:64];  pby = d[127:96];
        am  = d[128];   bm  = d[129];
        dx  = pbx - pax;
        dy  = pby - pay;
        fa  = '{0, 0};
        fb  = '{0, 0};
        clip = 1'b0;
        coin = (dx == 0) && (dy == 0);
        if (!coin)
        begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            sq = ax * ax + ay * ay;
            // exact integer square root, distance fits in 34 bits
            span = 0;
            for (int b = 33; b >= 0; b--)
            begin
                c = span | (128'd1 << b);
                if (c * c <= sq)
                    span = c;
            end
            sneg = span < rest_len;
            smag = sneg ? rest_len - span : span - rest_len;
            for (int k = 0; k < 2; k++)
            begin
                if (am)
                begin
                    r = force_comp(smag, sneg, k ? dy < 0 : dx < 0, k ? ay : ax, span, 0);
                    fa[k] = r[31:0];
                    clip |= r[32];
                end
                if (bm)
                begin
                    r = force_comp(smag, sneg, k ? dy < 0 : dx < 0, k ? ay : ax, span, 1);
                    fb[k] = r[31:0];
                    clip |= r[32];
                end
            end
        end
        pending_forces.push_back({4'b0, clip, coin, bm, am, fb[1], fb[0], fa[1], fa[0]});
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_forces(logic [135:0] got);
        logic [135:0] want;
        if (pending_forces.size() == 0)
        begin
            $error("result with no request outstanding: %0h", got);
            errors++;
            return;
        end
        want = pending_forces.pop_front();
        check_field("force_a_x",  want[31:0],   got[31:0]);
        check_field("force_a_y",  want[63:32],  got[63:32]);
        check_field("force_b_x",  want[95:64],  got[95:64]);
        check_field("force_b_y",  want[127:96], got[127:96]);
        check_field("apply_to_a", want[128],    got[128]);
        check_field("apply_to_b", want[129],    got[129]);
        check_field("coincident", want[130],    got[130]);
        check_field("saturated",  want[131],    got[131]);
    endfunction
endclass

module spring_force_2d_top_tb;
    import sfd_pkg::*;

    // indexes outside the register file, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int PIPE_LATENCY = 61;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    // pos_a_x, pos_a_y, pos_b_x, pos_b_y, a_movable, b_movable, zero pad
    logic [135:0]   s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    // force_a_x, force_a_y, force_b_x, force_b_y, apply_to_a, apply_to_b,
    // coincident, saturated, zero pad
    logic [135:0]   m_axis_tdata;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    force_scoreboard sb = new();

    int send_idle_pct  = 0;     // chance in a hundred of a sender gap cycle
    int recv_stall_pct = 0;     // chance in a hundred of a receiver stall cycle
    int hold_cycles    = 0;     // long receiver hold-off, counted down below

    spring_force_2d_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // outputs and ready are stable mid-cycle, so the transfer is judged there
    always @(negedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_forces(m_axis_tdata);

    // drive one body pair and hold it until the request is taken
    task automatic send_pair(logic [135:0] d);
        logic taken;
        int   gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        sb.note_pair(d);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_STIFFNESS)
            sb.stiffness = val;
        else if (idx == REG_REST_LEN)
            sb.rest_len = val[30:0];
    endtask

    // pause until every result is back, then let the pipe settle
    task automatic wait_drained();
        while (sb.pending_forces.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [135:0] pack_pair(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] bx, logic [31:0] by,
                                               logic am, logic bm);
        return {6'b0, bm, am, by, bx, ay, ax};
    endfunction

    // nearby pairs so the stretch stays meaningful, plus wide, edge and coincident cases
    function automatic logic [135:0] random_pair();
        logic [31:0] ax, ay, bx, by;
        int          sel;
        sel = $urandom_range(9);
        ax  = $urandom;
        ay  = $urandom;
        bx  = $urandom;
        by  = $urandom;
        if (sel >= 4 && sel <= 7)
        begin
            bx = ax + $signed($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            by = ay + $signed($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        end
        else if (sel == 8)
        begin
            ax = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            by = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (sel == 9)
        begin
            bx = ax;
            by = ay;
        end
        return pack_pair(ax, ay, bx, by, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic run_random(int count);
        repeat (count) send_pair(random_pair());
        idle_sender();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs on the reset register values
        send_pair(pack_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1, 1));
        send_pair(pack_pair(0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(0, 0, 32'h0003_0000, 32'h0004_0000, 1, 1));
        send_pair(pack_pair(0, 0, 32'h0003_0000, 32'h0004_0000, 1, 0));
        send_pair(pack_pair(0, 0, 32'h0003_0000, 32'h0004_0000, 0, 1));
        send_pair(pack_pair(0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0));
        send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1));
        send_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1));
        send_pair(pack_pair(32'h8000_0000, 0, 32'h8000_0000, 0, 1, 1));
        send_pair(pack_pair(0, 0, 1, 0, 1, 1));
        send_pair(pack_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
        send_pair(pack_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
        idle_sender();
        wait_drained();

        // compressed spring with big stiffness: direction flips, clipping
        write_reg(REG_REST_LEN, 32'h7FFF_FFFF);
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        send_pair(pack_pair(0, 0, 32'h0001_0000, 0, 1, 1));
        send_pair(pack_pair(0, 0, 0, 32'hFFFF_0000, 1, 0));
        send_pair(pack_pair(0, 0, 0, 32'hFFFF_0000, 0, 1));
        send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1));
        send_pair(pack_pair(5, 5, 5, 5, 1, 1));
        send_pair(pack_pair(0, 0, 32'h0000_8000, 32'h0000_8000, 1, 1));
        idle_sender();
        wait_drained();

        // zero stiffness, and writes to the unmapped indexes must change nothing
        write_reg(REG_STIFFNESS, 32'h0);
        write_reg(REG_REST_LEN, 32'h0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_pair(pack_pair(0, 0, 32'h0001_0000, 32'h0001_0000, 1, 1));
        idle_sender();
        wait_drained();

        // phase 1: stiffness 1.0, no idling, then a long hold-off on the output
        // while the sender keeps pushing so the pipe fills and backs up
        write_reg(REG_STIFFNESS, 32'h0001_0000);
        write_reg(REG_REST_LEN, 32'h0004_0000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(120);
        hold_cycles = 300;
        run_random(250);
        wait_drained();

        // phase 2: high stiffness, rest length at the top, sender mostly idle
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(REG_REST_LEN, 32'h7FFF_FFFF);
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        run_random(360);
        wait_drained();

        // phase 3: random stiffness, small rest, receiver mostly stalled
        write_reg(REG_STIFFNESS, $urandom);
        write_reg(REG_REST_LEN, $urandom_range(32'h0040_0000));
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random(360);
        wait_drained();

        // phase 4: light idling on both sides, fully random registers
        write_reg(REG_STIFFNESS, $urandom);
        write_reg(REG_REST_LEN, $urandom);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(360);
        wait_drained();

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
